// ----- rtl/ptps_pkg.sv -----
// shared types, constants and helper functions of the ptp end-to-end clock servo
package ptps_pkg;

   // working width of the datapath arithmetic
   localparam int unsigned WORK_W  = 128;
   localparam int unsigned MUL_B_W = 48;
   localparam int unsigned DIV_D_W = 64;

   // register indexes of the configuration port
   localparam logic [2:0] REG_COUNTER_BASE   = 3'd0;
   localparam logic [2:0] REG_NS_PER_TICK    = 3'd1;
   localparam logic [2:0] REG_OFFSET_GAIN    = 3'd2;
   localparam logic [2:0] REG_DELAY_GAIN     = 3'd3;
   localparam logic [2:0] REG_DRIFT_GAIN     = 3'd4;
   localparam logic [2:0] REG_LOCK_THRESHOLD = 3'd5;
   localparam logic [2:0] REG_LOCK_COUNT     = 3'd6;

   // register reset values
   localparam logic [47:0] NS_PER_TICK_RESET = 48'd429496729600;
   localparam logic [16:0] OFFSET_GAIN_RESET = 17'd6554;
   localparam logic [16:0] DELAY_GAIN_RESET  = 17'd6554;
   localparam logic [16:0] DRIFT_GAIN_RESET  = 17'd3277;
   localparam logic [29:0] LOCK_THR_RESET    = 30'd1000;
   localparam logic [7:0]  LOCK_COUNT_RESET  = 8'd8;

   // arithmetic constants
   localparam logic [16:0]         GAIN_ONE     = 17'd65536;
   localparam logic signed [127:0] MAX_DELAY_X2 = 128'sd2000000000;
   localparam logic signed [63:0]  MIN_DRIFT_DT = 64'sd100000000;
   localparam logic [47:0]         PPB_SCALE    = 48'd1000000000;
   localparam logic [7:0]          RUN_MAX      = 8'd255;

   // servo states
   typedef enum logic [1:0] {
      SERVO_FREE_RUN = 2'd0,
      SERVO_TRACKING = 2'd1,
      SERVO_LOCKED   = 2'd2
   } servo_state_type;

   // request word
   typedef struct packed {
      logic        action;
      logic [62:0] master_time_ns;
      logic [62:0] local_count;
   } req_type;

   // response word
   typedef struct packed {
      logic               status;
      logic signed [63:0] raw_offset_ns;
      logic signed [63:0] raw_delay_ns;
      logic signed [63:0] filtered_offset_ns;
      logic signed [63:0] filtered_delay_ns;
      logic signed [31:0] drift_ppb;
      logic [1:0]         lock_state;
   } rsp_type;

   // controller states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_T2_START,
      ST_T2_WAIT,
      ST_T3_START,
      ST_T3_WAIT,
      ST_FWD,
      ST_ODD,
      ST_CHECK,
      ST_OFF_START,
      ST_OFF_WAIT,
      ST_DLY_START,
      ST_DLY_WAIT,
      ST_DT,
      ST_DT_CHECK,
      ST_DRM_START,
      ST_DRM_WAIT,
      ST_DIV_WAIT,
      ST_DRA_START,
      ST_DRA_WAIT,
      ST_COMMIT,
      ST_OUT
   } ctrl_state_type;

   // datapath operations
   typedef enum logic [4:0] {
      OP_NONE,
      OP_SYNC,
      OP_LATCH,
      OP_MUL_T2,
      OP_T2,
      OP_MUL_T3,
      OP_T3,
      OP_FWD,
      OP_ODD,
      OP_MUL_OFF,
      OP_OFF_UPD,
      OP_MUL_DLY,
      OP_DLY_UPD,
      OP_DT,
      OP_MUL_DRIFT,
      OP_DIV,
      OP_RAW,
      OP_MUL_DRA,
      OP_DRA_UPD,
      OP_COMMIT,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic reject;
      logic drift_go;
      logic rsp_free;
   } dp_status_type;

   // saturate a signed value to a signed field of the given width
   function automatic logic signed [127:0] sat_to(input logic signed [127:0] v,
                                                  input int unsigned bits);
      logic signed [127:0] mx;
      logic signed [127:0] mn;
      mx = (128'sd1 <<< (bits - 1)) - 128'sd1;
      mn = -mx - 128'sd1;
      if (v > mx) begin
         return mx;
      end
      if (v < mn) begin
         return mn;
      end
      return v;
   endfunction

   // weights above one act as one
   function automatic logic [16:0] gain_clip(input logic [16:0] g);
      return (g > GAIN_ONE) ? GAIN_ONE : g;
   endfunction

endpackage

// ----- rtl/ptps_mul.sv -----
// shift-and-add multiplier, one multiplier bit per cycle
module ptps_mul (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [ptps_pkg::WORK_W-1:0]    a_in,
   input  logic [ptps_pkg::MUL_B_W-1:0]   b_in,
   output logic                           done,
   output logic [ptps_pkg::WORK_W-1:0]    prod
);
   import ptps_pkg::*;

   localparam int unsigned CNT_W = $clog2(MUL_B_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_B_W - 1);

   logic                busy_ff;
   logic                done_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [WORK_W-1:0]   a_ff;
   logic [MUL_B_W-1:0]  b_ff;
   logic [WORK_W-1:0]   acc_ff;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // accumulate shifted multiplicand
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a_in;
         b_ff   <= b_in;
         acc_ff <= '0;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_ff <= acc_ff + a_ff;
         end
         a_ff <= {a_ff[WORK_W-2:0], 1'b0};
         b_ff <= {1'b0, b_ff[MUL_B_W-1:1]};
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;
endmodule

// ----- rtl/ptps_div.sv -----
// restoring divider, one quotient bit per cycle
module ptps_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [ptps_pkg::WORK_W-1:0]    num_in,
   input  logic [ptps_pkg::DIV_D_W-1:0]   den_in,
   output logic                           done,
   output logic [ptps_pkg::WORK_W-1:0]    quot
);
   import ptps_pkg::*;

   localparam int unsigned CNT_W = $clog2(WORK_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORK_W - 1);

   logic                busy_ff;
   logic                done_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [WORK_W-1:0]   nq_ff;
   logic [DIV_D_W-1:0]  den_ff;
   logic [DIV_D_W-1:0]  rem_ff;
   logic [DIV_D_W:0]    trial;
   logic [DIV_D_W:0]    diff;
   logic                qbit;

   // one trial subtraction
   always_comb begin
      trial = {rem_ff, nq_ff[WORK_W-1]};
      diff  = trial - {1'b0, den_ff};
      qbit  = (trial >= {1'b0, den_ff});
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // numerator shifts out, quotient shifts in
   always_ff @(posedge clock) begin
      if (start) begin
         nq_ff  <= num_in;
         den_ff <= den_in;
         rem_ff <= '0;
      end else if (busy_ff) begin
         nq_ff  <= {nq_ff[WORK_W-2:0], qbit};
         rem_ff <= qbit ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
      end
   end

   assign done = done_ff;
   assign quot = nq_ff;
endmodule

// ----- rtl/ptps_dp.sv -----
// servo datapath: registers, estimates, multiplier and divider
module ptps_dp #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ptps_pkg::dp_cmd_type   cmd,
   output ptps_pkg::dp_status_type status,
   input  ptps_pkg::req_type      req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ptps_pkg::rsp_type      rsp_word,
   input  logic                   csr_valid,
   input  logic [2:0]             csr_index,
   input  logic [63:0]            csr_data
);
   import ptps_pkg::*;

   // configuration
   logic [62:0] base_ff;
   logic [47:0] nptq_ff;
   logic [16:0] ogain_ff;
   logic [16:0] dgain_ff;
   logic [16:0] rgain_ff;
   logic [29:0] thr_ff;
   logic [7:0]  need_ff;

   // servo state
   logic [62:0]        sync_master_ff;
   logic [62:0]        sync_count_ff;
   logic [1:0]         syncs_ff;
   logic signed [63:0] off_est_ff;
   logic signed [63:0] dly_est_ff;
   logic signed [47:0] drift_est_ff;
   logic signed [63:0] prev_upd_ff;
   servo_state_type    servo_ff;
   logic [7:0]         good_ff;

   // per-measurement working registers
   logic [62:0]         in_master_ff;
   logic [62:0]         in_count_ff;
   logic signed [127:0] t2_ff;
   logic signed [127:0] t3_ff;
   logic signed [127:0] fwd_ff;
   logic signed [127:0] bwd_ff;
   logic signed [127:0] od_ff;
   logic signed [127:0] dd_ff;
   logic                reject_ff;
   logic signed [63:0]  off_new_ff;
   logic signed [63:0]  dt_ff;
   logic signed [65:0]  delta_ff;
   logic signed [47:0]  raw_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   // units
   logic                mul_start;
   logic signed [127:0] mul_a;
   logic [47:0]         mul_b;
   logic                mul_done;
   logic signed [127:0] mul_prod;
   logic                div_done;
   logic [127:0]        div_quot;

   // combinational helpers
   logic signed [127:0] t2_sat;
   logic signed [127:0] od_sum;
   logic signed [127:0] dd_sum;
   logic signed [127:0] off_upd;
   logic signed [127:0] dly_upd;
   logic signed [127:0] dra_upd;
   logic signed [127:0] dt_sat;
   logic signed [127:0] raw_sat;
   logic signed [127:0] q_signed;
   logic signed [127:0] raw_off_sat;
   logic signed [127:0] raw_dly_sat;
   logic signed [127:0] drift_out_sat;
   logic [65:0]         delta_mag;
   logic signed [65:0]  thr1;
   logic signed [65:0]  thr2;
   logic signed [65:0]  off66;
   logic                in_band1;
   logic                in_band2;
   logic [7:0]          good_inc;
   servo_state_type     servo_in;
   logic [7:0]          good_in;
   logic [1:0]          syncs_in;

   // multiplier operand select
   always_comb begin
      mul_start = 1'b1;
      mul_a     = '0;
      mul_b     = nptq_ff;
      case (cmd.op)
         OP_MUL_T2: begin
            mul_a = 128'(sync_count_ff) - 128'(base_ff);
         end
         OP_MUL_T3: begin
            mul_a = 128'(in_count_ff) - 128'(base_ff);
         end
         OP_MUL_OFF: begin
            mul_a = sat_to(od_ff <<< (FRAC_BITS - 1), 64) - 128'(off_est_ff);
            mul_b = 48'(gain_clip(ogain_ff));
         end
         OP_MUL_DLY: begin
            mul_a = (dd_ff <<< (FRAC_BITS - 1)) - 128'(dly_est_ff);
            mul_b = 48'(gain_clip(dgain_ff));
         end
         OP_MUL_DRIFT: begin
            mul_a = 128'(delta_mag);
            mul_b = PPB_SCALE;
         end
         OP_MUL_DRA: begin
            mul_a = 128'(raw_ff) - 128'(drift_est_ff);
            mul_b = 48'(gain_clip(rgain_ff));
         end
         default: begin
            mul_start = 1'b0;
         end
      endcase
   end

   ptps_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a_in  (mul_a),
      .b_in  (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   ptps_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.op == OP_DIV),
      .num_in (mul_prod),
      .den_in (dt_ff),
      .done   (div_done),
      .quot   (div_quot)
   );

   // sums, saturations and lock band tests
   always_comb begin
      t2_sat        = sat_to(t2_ff, 64);
      od_sum        = fwd_ff - bwd_ff;
      dd_sum        = fwd_ff + bwd_ff;
      off_upd       = sat_to(128'(off_est_ff) + (mul_prod >>> 16), 64);
      dly_upd       = sat_to(128'(dly_est_ff) + (mul_prod >>> 16), 64);
      dra_upd       = sat_to(128'(drift_est_ff) + (mul_prod >>> 16), 48);
      dt_sat        = sat_to(t2_sat - 128'(prev_upd_ff), 64);
      q_signed      = delta_ff[65] ? -$signed(div_quot) : $signed(div_quot);
      raw_sat       = sat_to(q_signed, 48);
      raw_off_sat   = sat_to(od_ff >>> 1, 64);
      raw_dly_sat   = sat_to(dd_ff >>> 1, 64);
      drift_out_sat = sat_to(128'(drift_est_ff) >>> FRAC_BITS, 32);
      delta_mag     = delta_ff[65] ? 66'(-delta_ff) : 66'(delta_ff);
      thr1          = $signed(66'(thr_ff) << FRAC_BITS);
      thr2          = thr1 <<< 1;
      off66         = 66'(off_new_ff);
      in_band1      = (off66 < thr1) && (off66 > -thr1);
      in_band2      = (off66 < thr2) && (off66 > -thr2);
      good_inc      = (good_ff == RUN_MAX) ? RUN_MAX : good_ff + 8'd1;
      syncs_in      = (syncs_ff == 2'd2) ? 2'd2 : syncs_ff + 2'd1;
   end

   // servo state update of an accepted measurement
   always_comb begin
      servo_in = SERVO_TRACKING;
      good_in  = 8'd0;
      case (servo_ff)
         SERVO_TRACKING: begin
            if (in_band1) begin
               good_in = good_inc;
               if (good_inc >= need_ff) begin
                  servo_in = SERVO_LOCKED;
               end
            end
         end
         SERVO_LOCKED: begin
            if (in_band2) begin
               servo_in = SERVO_LOCKED;
               good_in  = good_ff;
            end
         end
         default: begin
            servo_in = SERVO_TRACKING;
         end
      endcase
   end

   // configuration and servo state
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff        <= '0;
         nptq_ff        <= NS_PER_TICK_RESET;
         ogain_ff       <= OFFSET_GAIN_RESET;
         dgain_ff       <= DELAY_GAIN_RESET;
         rgain_ff       <= DRIFT_GAIN_RESET;
         thr_ff         <= LOCK_THR_RESET;
         need_ff        <= LOCK_COUNT_RESET;
         sync_master_ff <= '0;
         sync_count_ff  <= '0;
         syncs_ff       <= '0;
         off_est_ff     <= '0;
         dly_est_ff     <= '0;
         drift_est_ff   <= '0;
         prev_upd_ff    <= '0;
         servo_ff       <= SERVO_FREE_RUN;
         good_ff        <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               REG_COUNTER_BASE:   base_ff  <= csr_data[62:0];
               REG_NS_PER_TICK:    nptq_ff  <= csr_data[47:0];
               REG_OFFSET_GAIN:    ogain_ff <= csr_data[16:0];
               REG_DELAY_GAIN:     dgain_ff <= csr_data[16:0];
               REG_DRIFT_GAIN:     rgain_ff <= csr_data[16:0];
               REG_LOCK_THRESHOLD: thr_ff   <= csr_data[29:0];
               REG_LOCK_COUNT:     need_ff  <= csr_data[7:0];
               default: begin
               end
            endcase
         end
         case (cmd.op)
            OP_SYNC: begin
               sync_master_ff <= req_word.master_time_ns;
               sync_count_ff  <= req_word.local_count;
               syncs_ff       <= syncs_in;
            end
            OP_DLY_UPD: dly_est_ff   <= dly_upd[63:0];
            OP_DRA_UPD: drift_est_ff <= dra_upd[47:0];
            OP_COMMIT: begin
               off_est_ff  <= off_new_ff;
               prev_upd_ff <= t2_sat[63:0];
               servo_ff    <= servo_in;
               good_ff     <= good_in;
            end
            default: begin
            end
         endcase
      end
   end

   // measurement working registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LATCH: begin
            in_master_ff <= req_word.master_time_ns;
            in_count_ff  <= req_word.local_count;
         end
         OP_T2:  t2_ff <= mul_prod >>> 32;
         OP_T3:  t3_ff <= mul_prod >>> 32;
         OP_FWD: begin
            fwd_ff <= t2_ff - 128'(sync_master_ff);
            bwd_ff <= 128'(in_master_ff) - t3_ff;
         end
         OP_ODD: begin
            od_ff     <= od_sum;
            dd_ff     <= dd_sum;
            reject_ff <= dd_sum[127] || (dd_sum > MAX_DELAY_X2);
         end
         OP_OFF_UPD: off_new_ff <= off_upd[63:0];
         OP_DT: begin
            dt_ff    <= dt_sat[63:0];
            delta_ff <= 66'(off_new_ff) - 66'(off_est_ff);
         end
         OP_RAW: raw_ff <= raw_sat[47:0];
         default: begin
         end
      endcase
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_OUT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_OUT) begin
         rsp_ff.status             <= reject_ff;
         rsp_ff.raw_offset_ns      <= raw_off_sat[63:0];
         rsp_ff.raw_delay_ns       <= raw_dly_sat[63:0];
         rsp_ff.filtered_offset_ns <= off_est_ff >>> FRAC_BITS;
         rsp_ff.filtered_delay_ns  <= dly_est_ff >>> FRAC_BITS;
         rsp_ff.drift_ppb          <= drift_out_sat[31:0];
         rsp_ff.lock_state         <= servo_ff;
      end
   end

   // status to the controller
   always_comb begin
      status.mul_done = mul_done;
      status.div_done = div_done;
      status.reject   = reject_ff;
      status.drift_go = (syncs_ff == 2'd2) && (sync_count_ff != '0) &&
                        (dt_ff > MIN_DRIFT_DT);
      status.rsp_free = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
endmodule

// ----- rtl/ptps_ctrl.sv -----
// servo controller: sequences the datapath through one measurement
module ptps_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_action,
   output logic                    req_ready,
   output ptps_pkg::dp_cmd_type    cmd,
   input  ptps_pkg::dp_status_type status
);
   import ptps_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_action) begin
               state_in = ST_T2_START;
            end
         end
         ST_T2_START: state_in = ST_T2_WAIT;
         ST_T2_WAIT:  if (status.mul_done) state_in = ST_T3_START;
         ST_T3_START: state_in = ST_T3_WAIT;
         ST_T3_WAIT:  if (status.mul_done) state_in = ST_FWD;
         ST_FWD:      state_in = ST_ODD;
         ST_ODD:      state_in = ST_CHECK;
         ST_CHECK:    state_in = status.reject ? ST_OUT : ST_OFF_START;
         ST_OFF_START: state_in = ST_OFF_WAIT;
         ST_OFF_WAIT: if (status.mul_done) state_in = ST_DLY_START;
         ST_DLY_START: state_in = ST_DLY_WAIT;
         ST_DLY_WAIT: if (status.mul_done) state_in = ST_DT;
         ST_DT:       state_in = ST_DT_CHECK;
         ST_DT_CHECK: state_in = status.drift_go ? ST_DRM_START : ST_COMMIT;
         ST_DRM_START: state_in = ST_DRM_WAIT;
         ST_DRM_WAIT: if (status.mul_done) state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: if (status.div_done) state_in = ST_DRA_START;
         ST_DRA_START: state_in = ST_DRA_WAIT;
         ST_DRA_WAIT: if (status.mul_done) state_in = ST_COMMIT;
         ST_COMMIT:   state_in = ST_OUT;
         ST_OUT:      if (status.rsp_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      cmd.op    = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = req_action ? OP_LATCH : OP_SYNC;
            end
         end
         ST_T2_START:  cmd.op = OP_MUL_T2;
         ST_T2_WAIT:   if (status.mul_done) cmd.op = OP_T2;
         ST_T3_START:  cmd.op = OP_MUL_T3;
         ST_T3_WAIT:   if (status.mul_done) cmd.op = OP_T3;
         ST_FWD:       cmd.op = OP_FWD;
         ST_ODD:       cmd.op = OP_ODD;
         ST_OFF_START: cmd.op = OP_MUL_OFF;
         ST_OFF_WAIT:  if (status.mul_done) cmd.op = OP_OFF_UPD;
         ST_DLY_START: cmd.op = OP_MUL_DLY;
         ST_DLY_WAIT:  if (status.mul_done) cmd.op = OP_DLY_UPD;
         ST_DT:        cmd.op = OP_DT;
         ST_DRM_START: cmd.op = OP_MUL_DRIFT;
         ST_DRM_WAIT:  if (status.mul_done) cmd.op = OP_DIV;
         ST_DIV_WAIT:  if (status.div_done) cmd.op = OP_RAW;
         ST_DRA_START: cmd.op = OP_MUL_DRA;
         ST_DRA_WAIT:  if (status.mul_done) cmd.op = OP_DRA_UPD;
         ST_COMMIT:    cmd.op = OP_COMMIT;
         ST_OUT:       if (status.rsp_free) cmd.op = OP_OUT;
         default:      cmd.op = OP_NONE;
      endcase
   end
endmodule

// ----- rtl/ptp_e2e_clock_servo.sv -----
// top level of the ptp end-to-end offset, delay and drift servo
// sync word: no response word, input ready again the next cycle
// delay word: response loaded after the T2, T3 multiplies if rejected, plus the offset
//   and delay updates if accepted, plus drift multiplies and divide on a drift update
// one word at a time; input ready again the cycle after the response register is loaded
// synchronous reset restores register defaults, clears all servo state to free run
module ptp_e2e_clock_servo #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ptps_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ptps_pkg::rsp_type rsp_word,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [63:0]       csr_data
);
   import ptps_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // registers are always writable
   assign csr_ready = 1'b1;

   ptps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_word.action),
      .req_ready  (req_ready),
      .cmd        (cmd),
      .status     (status)
   );

   ptps_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );
endmodule

// ----- rtl/ptps_checker.sv -----
// port-level checks of the servo, bound to the top level
module ptps_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input ptps_pkg::req_type req_word,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ptps_pkg::rsp_type rsp_word
);
   import ptps_pkg::*;

   // response word holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped before taken");

   // a sync word makes no response
   a_sync_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_word.action && !rsp_valid |=> !rsp_valid)
      else $error("response after sync word");

   // a delay word keeps the block busy
   a_delay_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_word.action |=> !req_ready)
      else $error("input ready right after delay word");

   // an accepted measurement leaves free run and has a sane delay
   a_accept_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.status |->
         (rsp_word.lock_state != SERVO_FREE_RUN) && !rsp_word.raw_delay_ns[63])
      else $error("accepted measurement with bad state or delay");
endmodule

bind ptp_e2e_clock_servo ptps_checker u_ptps_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);

// ----- tb/servo_estimate_checker.sv -----
// checker for the ptp servo: predicts each delay response word and compares it field by field
module servo_estimate_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  ptps_pkg::req_type req_word,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  ptps_pkg::rsp_type rsp_word,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [63:0]       csr_data,
   output int                pending,
   output int                fail_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import ptps_pkg::*;

   // predicted configuration
   logic [62:0] cbase;
   logic [47:0] npt;
   logic [16:0] og, dg, drg;
   logic [29:0] thr_ns;
   logic [7:0]  lock_need;

   // predicted servo state
   logic [62:0]        sync_t1, sync_cnt;
   logic [1:0]         syncs_seen;
   logic signed [63:0] off_est, dly_est;
   logic signed [47:0] drift_est;
   logic [63:0]        last_update_ns;
   servo_state_type    servo;
   logic [7:0]         run_cnt;

   rsp_type expected_reports[$];

   assign pending = expected_reports.size();

   function automatic logic signed [127:0] clamp_signed(input logic signed [127:0] v,
                                                        input int bits);
      logic signed [127:0] mx, mn;
      mx = (128'sd1 <<< (bits - 1)) - 128'sd1;
      mn = -mx - 128'sd1;
      if (v > mx) return mx;
      if (v < mn) return mn;
      return v;
   endfunction

   // local counter value to nanoseconds
   function automatic logic signed [127:0] count_to_ns(input logic [62:0] cnt);
      logic signed [127:0] diff;
      diff = $signed({65'd0, cnt}) - $signed({65'd0, cbase});
      return (diff * $signed({80'd0, npt})) >>> 32;
   endfunction

   // exponential average step
   function automatic logic signed [127:0] blend(input logic signed [127:0] est,
                                                 input logic signed [127:0] sample,
                                                 input logic [16:0] gain, input int bits);
      logic [16:0] g;
      logic signed [127:0] step;
      g = (gain > 17'd65536) ? 17'd65536 : gain;
      step = ((sample - est) * $signed({111'd0, g})) >>> 16;
      return clamp_signed(est + step, bits);
   endfunction

   // one delay word: measurement, servo update and report
   task automatic predict_delay(input req_type w, output rsp_type r);
      logic signed [127:0] t2, fwd, bwd, od, dd, prev_off, off, t2s, dt, delta, q, raw, tmp;
      logic signed [127:0] thr;
      logic rej;
      t2  = count_to_ns(sync_cnt);
      fwd = t2 - $signed({65'd0, sync_t1});
      bwd = $signed({65'd0, w.master_time_ns}) - count_to_ns(w.local_count);
      od  = fwd - bwd;
      dd  = fwd + bwd;
      rej = (dd < 0) || (dd > 128'sd2000000000);
      if (!rej) begin
         prev_off = off_est;
         off = blend(prev_off, clamp_signed(od <<< 15, 64), og, 64);
         off_est = off[63:0];
         tmp = blend(dly_est, dd <<< 15, dg, 64);
         dly_est = tmp[63:0];
         t2s = clamp_signed(t2, 64);
         if (syncs_seen >= 2 && sync_cnt != 0) begin
            dt = clamp_signed(t2s - $signed(last_update_ns), 64);
            if (dt > 128'sd100000000) begin
               delta = off - prev_off;
               q = (delta * 128'sd1000000000) / dt;
               raw = clamp_signed(q, 48);
               tmp = blend(drift_est, raw, drg, 48);
               drift_est = tmp[47:0];
            end
         end
         last_update_ns = t2s[63:0];
         // free run, tracking, locked
         if (servo == SERVO_TRACKING) begin
            thr = $signed({98'd0, thr_ns}) <<< 16;
            if (off < thr && -thr < off) begin
               if (run_cnt != 8'd255) run_cnt = run_cnt + 8'd1;
               if (run_cnt >= lock_need) servo = SERVO_LOCKED;
            end else begin
               run_cnt = 0;
            end
         end else if (servo == SERVO_LOCKED) begin
            thr = $signed({98'd0, thr_ns}) <<< 17;
            if (!(off < thr) || !(-thr < off)) begin
               servo = SERVO_TRACKING;
               run_cnt = 0;
            end
         end else begin
            servo = SERVO_TRACKING;
            run_cnt = 0;
         end
      end
      r.status = rej;
      tmp = clamp_signed(od >>> 1, 64);
      r.raw_offset_ns = tmp[63:0];
      tmp = clamp_signed(dd >>> 1, 64);
      r.raw_delay_ns = tmp[63:0];
      r.filtered_offset_ns = off_est >>> 16;
      r.filtered_delay_ns = dly_est >>> 16;
      tmp = clamp_signed($signed(drift_est) >>> 16, 32);
      r.drift_ppb = tmp[31:0];
      r.lock_state = servo;
   endtask

   // compare one response word with the oldest prediction
   task automatic compare_report(input rsp_type got);
      rsp_type e;
      if (expected_reports.size() == 0) begin
         $error("response word with no prediction waiting");
         fail_count++;
         return;
      end
      e = expected_reports.pop_front();
      if (got.status !== e.status) begin
         $error("status: expected %0d, actual %0d", e.status, got.status);
         fail_count++;
      end
      if (got.raw_offset_ns !== e.raw_offset_ns) begin
         $error("raw_offset_ns: expected %0d, actual %0d", e.raw_offset_ns, got.raw_offset_ns);
         fail_count++;
      end
      if (got.raw_delay_ns !== e.raw_delay_ns) begin
         $error("raw_delay_ns: expected %0d, actual %0d", e.raw_delay_ns, got.raw_delay_ns);
         fail_count++;
      end
      if (got.filtered_offset_ns !== e.filtered_offset_ns) begin
         $error("filtered_offset_ns: expected %0d, actual %0d",
                e.filtered_offset_ns, got.filtered_offset_ns);
         fail_count++;
      end
      if (got.filtered_delay_ns !== e.filtered_delay_ns) begin
         $error("filtered_delay_ns: expected %0d, actual %0d",
                e.filtered_delay_ns, got.filtered_delay_ns);
         fail_count++;
      end
      if (got.drift_ppb !== e.drift_ppb) begin
         $error("drift_ppb: expected %0d, actual %0d", e.drift_ppb, got.drift_ppb);
         fail_count++;
      end
      if (got.lock_state !== e.lock_state) begin
         $error("lock_state: expected %0d, actual %0d", e.lock_state, got.lock_state);
         fail_count++;
      end
   endtask

   initial fail_count = 0;

   // watch all three channels
   always @(posedge clock) begin
      rsp_type r;
      if (reset) begin
         cbase = 0; npt = NS_PER_TICK_RESET;
         og = OFFSET_GAIN_RESET; dg = DELAY_GAIN_RESET; drg = DRIFT_GAIN_RESET;
         thr_ns = LOCK_THR_RESET; lock_need = LOCK_COUNT_RESET;
         sync_t1 = 0; sync_cnt = 0; syncs_seen = 0;
         off_est = 0; dly_est = 0; drift_est = 0; last_update_ns = 0;
         servo = SERVO_FREE_RUN; run_cnt = 0;
         expected_reports.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_COUNTER_BASE:   cbase = csr_data[62:0];
               REG_NS_PER_TICK:    npt = csr_data[47:0];
               REG_OFFSET_GAIN:    og = csr_data[16:0];
               REG_DELAY_GAIN:     dg = csr_data[16:0];
               REG_DRIFT_GAIN:     drg = csr_data[16:0];
               REG_LOCK_THRESHOLD: thr_ns = csr_data[29:0];
               REG_LOCK_COUNT:     lock_need = csr_data[7:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_word.action == 1'b0) begin
               sync_t1 = req_word.master_time_ns;
               sync_cnt = req_word.local_count;
               if (syncs_seen < 2) syncs_seen = syncs_seen + 2'd1;
            end else begin
               predict_delay(req_word, r);
               expected_reports.push_back(r);
            end
         end
         if (rsp_valid && rsp_ready) compare_report(rsp_word);
      end
   end

endmodule

// ----- tb/tb_ptp_e2e_clock_servo.sv -----
// testbench top of the ptp end-to-end clock servo: stimulus, stalls and verdict
module tb_ptp_e2e_clock_servo;
   timeunit 1ns;
   timeprecision 1ps;
   import ptps_pkg::*;

   localparam int IDLE_LIMIT = 40000;
   localparam int DRAIN_CYCLES = 600;
   localparam int PHASES = 7;

   logic       clock, reset;
   logic       req_valid, req_ready, rsp_valid, rsp_ready, csr_valid, csr_ready;
   req_type    req_word;
   rsp_type    rsp_word;
   logic [2:0] csr_index;
   logic [63:0] csr_data;
   int         pending, fail_count;

   // stimulus-side copy of the conversion registers
   logic [62:0] cb;
   logic [47:0] npt;
   logic [62:0] cnt;
   logic        calm;
   int          sent, idle_cycles, hold, k;

   ptp_e2e_clock_servo uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   servo_estimate_checker chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data), .pending(pending), .fail_count(fail_count)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // result side: random stall after each word, none in calm phases
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold <= 0;
      end else if (hold != 0) begin
         hold <= hold - 1;
         if (hold == 1) rsp_ready <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
         k = calm ? 0 : $urandom_range(0, 3);
         if (k != 0) begin
            rsp_ready <= 1'b0;
            hold <= k;
         end
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   function automatic logic signed [127:0] count_ns(input logic [62:0] c);
      logic signed [127:0] diff;
      diff = $signed({65'd0, c}) - $signed({65'd0, cb});
      return (diff * $signed({80'd0, npt})) >>> 32;
   endfunction

   function automatic logic [62:0] to_field(input logic signed [127:0] v);
      if (v < 0) return 63'd0;
      if (v > 128'sh7FFFFFFFFFFFFFFF) return {63{1'b1}};
      return v[62:0];
   endfunction

   task automatic send_word(input logic act, input logic [62:0] mt, input logic [62:0] lc);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= '{action: act, master_time_ns: mt, local_count: lc};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   // sync then delay with a chosen offset and path delay
   task automatic exchange(input longint ofs, input longint dly);
      logic [62:0] c3;
      logic signed [127:0] t2ns;
      t2ns = count_ns(cnt);
      c3 = cnt + 63'($urandom_range(0, 1000));
      send_word(1'b0, to_field(t2ns - ofs - dly), cnt);
      send_word(1'b1, to_field(count_ns(c3) + dly - ofs), c3);
   endtask

   task automatic advance_counter();
      logic [127:0] span;
      span = (npt == 0) ? 128'd1000000 : ((128'd200000000 << 32) / npt);
      if (span > 128'd1 << 40) span = 128'd1 << 40;
      cnt = cnt + 63'((span * $urandom_range(1, 8)) / 4);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      if (idx == REG_COUNTER_BASE) cb = val[62:0];
      if (idx == REG_NS_PER_TICK) npt = val[47:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // stop sending, then wait for every response word and let the block go quiet
   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_settings(input int p);
      case (p)
         1: begin
            write_reg(REG_COUNTER_BASE, 64'd12345);
            write_reg(REG_NS_PER_TICK, 64'd1 << 32);
            write_reg(REG_OFFSET_GAIN, 64'd65536);
            write_reg(REG_DELAY_GAIN, 64'd65536);
            write_reg(REG_DRIFT_GAIN, 64'd65536);
            write_reg(REG_LOCK_THRESHOLD, 64'd1000000000);
            write_reg(REG_LOCK_COUNT, 64'd1);
         end
         2: begin
            write_reg(REG_COUNTER_BASE, 64'd0);
            write_reg(REG_NS_PER_TICK, 64'd1);
            write_reg(REG_OFFSET_GAIN, 64'd0);
            write_reg(REG_DELAY_GAIN, 64'd0);
            write_reg(REG_DRIFT_GAIN, 64'd0);
            write_reg(REG_LOCK_THRESHOLD, 64'd0);
            write_reg(REG_LOCK_COUNT, 64'd255);
         end
         3: begin
            write_reg(REG_COUNTER_BASE, 64'h7FFFFFFFFFFFFFFF);
            write_reg(REG_NS_PER_TICK, 64'hFFFFFFFFFFFF);
            write_reg(REG_OFFSET_GAIN, 64'd131071);
            write_reg(REG_DELAY_GAIN, 64'd1);
            write_reg(REG_DRIFT_GAIN, 64'd32768);
            write_reg(REG_LOCK_THRESHOLD, 64'd500);
            write_reg(REG_LOCK_COUNT, 64'd3);
         end
         4: begin
            // upper bits beyond each register width are ignored
            write_reg(REG_COUNTER_BASE, {$urandom, $urandom} & 64'hFF_FFFF_FFFF);
            write_reg(REG_NS_PER_TICK, {16'hDEAD, 48'd107374182400});
            write_reg(REG_OFFSET_GAIN, {47'h5A5A, 17'd20000});
            write_reg(REG_DELAY_GAIN, 64'd8000);
            write_reg(REG_DRIFT_GAIN, 64'd3000);
            write_reg(REG_LOCK_THRESHOLD, {34'h3, 30'd2000});
            write_reg(REG_LOCK_COUNT, {56'hFF, 8'd8});
         end
         5: begin
            write_reg(REG_COUNTER_BASE, 64'd77);
            write_reg(REG_NS_PER_TICK, 64'd0);
            write_reg(REG_LOCK_THRESHOLD, 64'd1000000000);
            write_reg(REG_LOCK_COUNT, 64'd0);
         end
         default: begin
            write_reg(REG_COUNTER_BASE, 64'd0);
            write_reg(REG_NS_PER_TICK, 64'd429496729600);
            write_reg(REG_OFFSET_GAIN, 64'd6554);
            write_reg(REG_DELAY_GAIN, 64'd6554);
            write_reg(REG_DRIFT_GAIN, 64'd3277);
            write_reg(REG_LOCK_THRESHOLD, 64'd1000);
            write_reg(REG_LOCK_COUNT, 64'd8);
         end
      endcase
      csr_valid <= 1'b0;
   endtask

   // one random step: mostly clean exchanges, some noise and broken ones
   task automatic random_step();
      int pick;
      longint ofs, dly;
      pick = $urandom_range(0, 99);
      advance_counter();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: ofs = longint'($urandom_range(0, 3000)) - 1500;
         5, 6, 7:       ofs = longint'($urandom_range(0, 2000000)) - 1000000;
         default:       ofs = $signed({$urandom, $urandom}) >>> 23;
      endcase
      dly = ($urandom_range(0, 19) == 0) ? 64'd1000000000 : $urandom_range(0, 1000000);
      if (pick < 70) begin
         exchange(ofs, dly);
      end else if (pick < 80) begin
         send_word($urandom_range(0, 1), {$urandom, $urandom}, {$urandom, $urandom});
      end else if (pick < 90) begin
         send_word(1'b0, {$urandom, $urandom}, {$urandom, $urandom});
         exchange(ofs, dly);
      end else begin
         exchange(ofs, ($urandom_range(0, 1) == 0) ? -longint'($urandom_range(1, 5000))
                                                   : 64'd1000000001 + $urandom);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      calm = 1'b0;
      sent = 0;
      cb = 0;
      npt = NS_PER_TICK_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: delay before any sync, field extremes, delay limits
      send_word(1'b1, 63'd0, 63'd0);
      send_word(1'b1, {63{1'b1}}, {63{1'b1}});
      send_word(1'b0, {63{1'b1}}, {63{1'b1}});
      send_word(1'b1, {63{1'b1}}, {63{1'b1}});
      send_word(1'b0, 63'd0, 63'd0);
      send_word(1'b1, 63'd0, 63'd0);
      cnt = 63'd50000000;
      exchange(0, 0);
      advance_counter();
      exchange(400, 1000000000);
      advance_counter();
      exchange(-400, 1000000001);
      advance_counter();
      exchange(20, -1);
      repeat (4) begin
         advance_counter();
         exchange(longint'($urandom_range(0, 200)) - 100, 5000);
      end
      advance_counter();
      exchange(64'sd1 <<< 40, 3000);

      for (int p = 0; p < PHASES; p++) begin
         if (p != 0) begin
            settle();
            load_settings(p);
         end
         calm = (p % 3 == 2);
         cnt = cb + 63'd1000000;
         while (sent < (p + 1) * 160) random_step();
      end

      settle();
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/ptps_pkg.sv
rtl/ptps_mul.sv
rtl/ptps_div.sv
rtl/ptps_dp.sv
rtl/ptps_ctrl.sv
rtl/ptp_e2e_clock_servo.sv
rtl/ptps_checker.sv
tb/servo_estimate_checker.sv
tb/tb_ptp_e2e_clock_servo.sv
